// ===== design/aes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_pkg: shared constants, types and functions
// S-box tables, GF(2^8) helpers and register indexes for the AES core.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int KeyDepth = 60;
  localparam int KeyAw    = 6;

  localparam logic [2:0] CFG_KEY0  = 3'd0;
  localparam logic [2:0] CFG_KEY1  = 3'd1;
  localparam logic [2:0] CFG_KEY2  = 3'd2;
  localparam logic [2:0] CFG_KEY3  = 3'd3;
  localparam logic [2:0] CFG_KSIZE = 3'd4;
  localparam logic [2:0] CFG_CHAIN = 3'd5;
  localparam logic [2:0] CFG_IVHI  = 3'd6;
  localparam logic [2:0] CFG_IVLO  = 3'd7;

  localparam logic OP_ENC = 1'b0;
  localparam logic OP_DEC = 1'b1;

  typedef struct packed {
    logic              en;
    logic [KeyAw-1:0]  addr;
    logic [31:0]       data;
  } rk_wr_t;

  typedef logic [7:0] sbox_arr_t [256];

  localparam sbox_arr_t SboxFwd = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam sbox_arr_t SboxInv = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SboxFwd[w[31:24]], SboxFwd[w[23:16]], SboxFwd[w[15:8]], SboxFwd[w[7:0]]};
  endfunction

endpackage

// ===== design/aes_block_cipher_ecb_cbc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_block_cipher_ecb_cbc_core: AES-128/192/256 in ECB or CBC mode
// Iterative core: one shared round unit, round keys held in a local memory.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  in_     | request   | in_valid/in_ready, operation, block halves, end flag
//  out_    | result    | out_valid/out_ready, result halves, end flag
//  cfg_    | write     | cfg_we, cfg_index, cfg_wdata
//
// Each request runs through all of its rounds before its result is valid, and
// no new request is taken until that result leaves: the key store has one
// read port, so each round reads its four key words one after another.
// A key or key size write runs a 44 to 60 word expansion; requests wait.
// Reset is synchronous and clears control state; a held result waits on
// out_ready with no new request taken until it leaves.
module aes_block_cipher_ecb_cbc_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  input  logic        in_message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic        out_result_end,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);
  import aes_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [63:0]  key_r [4];
  logic [1:0]   ksize_r;
  logic         chain_r;
  logic [63:0]  ivh_r, ivl_r;
  logic [127:0] cv_r;
  logic [1:0]   state_r, state_nxt;
  logic [127:0] st_r, rkacc_r, in_blk_r, res_r;
  logic         dec_r, end_r;
  logic [3:0]   rnd_r;         // round number being keyed
  logic [1:0]   col_r;         // key word column
  logic [1:0]   col_d_r;       // column of data arriving from the store
  logic         rd_pend_r;
  logic [3:0]   done_r;        // rounds completed
  logic [3:0]   nr;
  logic [31:0]  rk_mem [KeyDepth];
  logic [31:0]  rk_q_r;
  logic [KeyAw-1:0] rd_addr;
  rk_wr_t       kwr;
  logic         kbusy, kstart;
  logic [127:0] rnd_res, blk_in;
  logic [127:0] rk_cur;
  logic         last;

  assign nr = (ksize_r == 2'd0) ? 4'd10 : (ksize_r == 2'd1) ? 4'd12 : 4'd14;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 4; k++) key_r[k] <= '0;
      ksize_r <= '0;
      chain_r <= 1'b0;
      ivh_r   <= '0;
      ivl_r   <= '0;
      cv_r    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY0:  key_r[0] <= cfg_wdata;
          CFG_KEY1:  key_r[1] <= cfg_wdata;
          CFG_KEY2:  key_r[2] <= cfg_wdata;
          CFG_KEY3:  key_r[3] <= cfg_wdata;
          CFG_KSIZE: ksize_r  <= (cfg_wdata[1:0] == 2'd3) ? 2'd2 : cfg_wdata[1:0];
          CFG_CHAIN: chain_r  <= cfg_wdata[0];
          CFG_IVHI:  begin ivh_r <= cfg_wdata; cv_r <= {cfg_wdata, ivl_r}; end
          CFG_IVLO:  begin ivl_r <= cfg_wdata; cv_r <= {ivh_r, cfg_wdata}; end
          default:   ;
        endcase
      end else if (state_r == ST_RUN && last && col_d_r == 2'd3 && rd_pend_r
                   && chain_r) begin
        // advance chaining value at the end of a block
        cv_r <= dec_r ? in_blk_r : rnd_res;
      end
    end
  end

  // start expansion in the cycle after a key write so the register is updated
  always_ff @(posedge clk) begin
    if (!rst_n) kstart <= 1'b0;
    else        kstart <= cfg_we && (cfg_index == CFG_KEY0 || cfg_index == CFG_KEY1 ||
                                     cfg_index == CFG_KEY2 || cfg_index == CFG_KEY3 ||
                                     cfg_index == CFG_KSIZE);
  end

  aes_key_exp u_kexp (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (kstart),
    .key      ({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .key_size (ksize_r),
    .wr       (kwr),
    .busy     (kbusy)
  );

  // round key store: one write, one registered read
  always_ff @(posedge clk) begin
    if (kwr.en) rk_mem[kwr.addr] <= kwr.data;
    rk_q_r <= rk_mem[rd_addr];
  end

  // key address: encrypt walks rounds up, decrypt walks down
  always_comb begin
    logic [3:0] r;
    r       = dec_r ? nr - rnd_r : rnd_r;
    rd_addr = KeyAw'({r, col_r});
  end

  assign last = (done_r == nr);
  assign blk_in = (in_operation == OP_ENC && chain_r) ?
                  ({in_block_high, in_block_low} ^ cv_r) : {in_block_high, in_block_low};

  // round unit sees the full key once the fourth word lands
  // (rkacc_r low word is replaced by rk_q_r on the applying cycle)
  assign rk_cur = {rkacc_r[127:32], rk_q_r};

  aes_round u_round (
    .st   (st_r),
    .rk   (rk_cur),
    .dec  (dec_r),
    .last (last),
    .res  (rnd_res)
  );

  assign in_ready = (state_r == ST_IDLE) && !kbusy && !kstart;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid && in_ready) state_nxt = ST_LOAD;
      ST_LOAD: if (rd_pend_r && col_d_r == 2'd3) state_nxt = ST_RUN;
      ST_RUN:  if (rd_pend_r && col_d_r == 2'd3 && last) state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer: issue four key reads per round, apply round on the fourth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_r     <= '0;
      col_r     <= '0;
      col_d_r   <= '0;
      rd_pend_r <= 1'b0;
      done_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          rnd_r     <= '0;
          col_r     <= '0;
          done_r    <= '0;
          rd_pend_r <= 1'b0;
        end
        ST_LOAD, ST_RUN: begin
          rd_pend_r <= 1'b1;
          col_d_r   <= col_r;
          col_r     <= col_r + 2'd1;
          if (col_r == 2'd3) rnd_r <= rnd_r + 4'd1;
          if (rd_pend_r && col_d_r == 2'd3) done_r <= done_r + 4'd1;
        end
        default: rd_pend_r <= 1'b0;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && in_ready) begin
      st_r     <= blk_in;
      in_blk_r <= {in_block_high, in_block_low};
      dec_r    <= in_operation;
      end_r    <= in_message_end;
    end
    if ((state_r == ST_LOAD || state_r == ST_RUN) && rd_pend_r) begin
      rkacc_r[127-32*col_d_r -: 32] <= rk_q_r;
      if (col_d_r == 2'd3) begin
        // key for this round complete: apply with the arriving word
        if (state_r == ST_LOAD) st_r <= st_r ^ rk_cur;
        else                    st_r <= rnd_res;
      end
    end
    if (state_r == ST_RUN && rd_pend_r && col_d_r == 2'd3 && last) begin
      res_r <= (dec_r && chain_r) ? (rnd_res ^ cv_r) : rnd_res;
    end
  end

  assign out_valid       = (state_r == ST_OUT);
  assign out_result_high = res_r[127:64];
  assign out_result_low  = res_r[63:0];
  assign out_result_end  = end_r;

endmodule

// ===== design/aes_key_exp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_key_exp: round key expansion sequencer
// Produces one key schedule word per cycle and writes it to the key store.
// ----------------------------------------------------------------------------
module aes_key_exp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [255:0]        key,
  input  logic [1:0]          key_size,
  output aes_pkg::rk_wr_t     wr,
  output logic                busy
);
  import aes_pkg::*;

  logic [KeyAw-1:0] idx_r, idx_nxt;
  logic [KeyAw-1:0] total;
  logic [3:0]       nk;
  logic [2:0]       pos_r, pos_nxt;    // i mod nk
  logic [7:0]       rcon_r, rcon_nxt;
  logic             busy_r, busy_nxt;
  logic [31:0]      win_r [8];         // sliding window of the last nk words
  logic [31:0]      w_new, t, prev;
  logic [KeyAw-1:0] out_idx;

  always_comb begin
    case (key_size)
      2'd0:    begin nk = 4'd4; total = 6'd44; end
      2'd1:    begin nk = 4'd6; total = 6'd52; end
      default: begin nk = 4'd8; total = 6'd60; end
    endcase
  end

  // compute next word from the window (win_r[0] oldest, win_r[nk-1] newest)
  always_comb begin
    prev = win_r[nk[2:0] - 3'd1];
    t    = prev;
    if (pos_r == 3'd0) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_r, 24'h0};
    end else if (nk == 4'd8 && pos_r == 3'd4) begin
      t = sub_word(prev);
    end
    w_new = win_r[0] ^ t;
  end

  always_comb begin
    idx_nxt  = idx_r;
    pos_nxt  = pos_r;
    rcon_nxt = rcon_r;
    busy_nxt = busy_r;
    if (start) begin
      idx_nxt  = '0;
      busy_nxt = 1'b1;
      pos_nxt  = '0;
      rcon_nxt = 8'h01;
    end else if (busy_r) begin
      idx_nxt = idx_r + 6'd1;
      if (idx_r >= {2'b0, nk}) begin
        pos_nxt = (pos_r == nk[2:0] - 3'd1) ? 3'd0 : pos_r + 3'd1;
        if (pos_r == 3'd0) rcon_nxt = xt(rcon_r);
      end
      if (idx_r == total - 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
      pos_r  <= '0;
      rcon_r <= 8'h01;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
      rcon_r <= rcon_nxt;
    end
  end

  // load the key words, then slide the window one word per step
  // (entries above nk-1 are don't-care)
  always_ff @(posedge clk) begin
    if (start) begin
      for (int k = 0; k < 8; k++) win_r[k] <= key[255-32*k -: 32];
    end else if (busy_r && idx_r >= {2'b0, nk}) begin
      for (int k = 0; k < 7; k++)
        win_r[k] <= (k[2:0] == nk[2:0] - 3'd1) ? w_new : win_r[k+1];
      win_r[7] <= w_new;
    end
  end

  assign out_idx = idx_r;
  always_comb begin
    wr.en   = busy_r;
    wr.addr = out_idx;
    wr.data = (idx_r < {2'b0, nk}) ? win_r[idx_r[2:0]] : w_new;
  end
  assign busy = busy_r;

endmodule

// ===== design/aes_round.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_round: shared round unit
// One encrypt or decrypt round on the 128-bit state (the last round skips the column mix), combinational.
// ----------------------------------------------------------------------------
module aes_round (
  input  logic [127:0] st,
  input  logic [127:0] rk,
  input  logic         dec,
  input  logic         last,
  output logic [127:0] res
);
  import aes_pkg::*;

  logic [7:0]   s  [16];
  logic [7:0]   sr [16];
  logic [7:0]   sb [16];
  logic [7:0]   mx [16];
  logic [127:0] sb_v, mx_v, ak_v;
  logic [7:0]   a0, a1, a2, a3, b0, b1, b2, b3, u, v;

  always_comb begin
    for (int i = 0; i < 16; i++) s[i] = st[127-8*i -: 8];
    // shift rows then substitute (order commutes)
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (dec) sr[r + 4*((c+r) & 3)] = s[r + 4*c];
        else     sr[r + 4*c] = s[r + 4*((c+r) & 3)];
      end
    end
    for (int i = 0; i < 16; i++) begin
      sb[i] = dec ? SboxInv[sr[i]] : SboxFwd[sr[i]];
      sb_v[127-8*i -: 8] = sb[i];
    end
    ak_v = sb_v ^ rk;
    // mix input: encrypt mixes before key add, decrypt after
    for (int c = 0; c < 4; c++) begin
      a0 = dec ? ak_v[127-32*c -: 8]  : sb[4*c];
      a1 = dec ? ak_v[119-32*c -: 8]  : sb[4*c+1];
      a2 = dec ? ak_v[111-32*c -: 8]  : sb[4*c+2];
      a3 = dec ? ak_v[103-32*c -: 8]  : sb[4*c+3];
      // inverse mix as pre-multiply then forward mix
      u  = xt(xt(a0 ^ a2));
      v  = xt(xt(a1 ^ a3));
      b0 = dec ? a0 ^ u : a0;
      b1 = dec ? a1 ^ v : a1;
      b2 = dec ? a2 ^ u : a2;
      b3 = dec ? a3 ^ v : a3;
      mx[4*c]   = xt(b0) ^ xt(b1) ^ b1 ^ b2 ^ b3;
      mx[4*c+1] = b0 ^ xt(b1) ^ xt(b2) ^ b2 ^ b3;
      mx[4*c+2] = b0 ^ b1 ^ xt(b2) ^ xt(b3) ^ b3;
      mx[4*c+3] = xt(b0) ^ b0 ^ b1 ^ b2 ^ xt(b3);
    end
    for (int i = 0; i < 16; i++) mx_v[127-8*i -: 8] = mx[i];
    if (last)     res = ak_v;
    else if (dec) res = mx_v;
    else          res = mx_v ^ rk;
  end

endmodule

// ===== design/aes_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes_checker: port level checks for the AES core
// Watches the handshakes of the core and flags illegal sequences.
// ----------------------------------------------------------------------------
module aes_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_result_high
);

  // no request taken while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("request taken with result pending");

  // a result never follows its request in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !out_valid) else $error("result too early");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_result_high)))
    else $error("result dropped under stall");

  // after a taken request the core is not ready at once for another
  a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready during work");

endmodule

bind aes_block_cipher_ecb_cbc_core aes_checker u_aes_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_result_high (out_result_high)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the AES ECB/CBC block cipher core
// Requests are pushed through a valid/ready driver with random gaps. Every
// accepted request is run through a local AES model with its own key schedule
// and chaining value. Results are compared field by field with the oldest
// expected block, while the result side stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import aes_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 70;

  typedef struct {
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } blk_req_t;

  typedef struct {
    logic [63:0] hi;
    logic [63:0] lo;
    logic        last;
  } blk_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [63:0] in_block_high;
  logic [63:0] in_block_low;
  logic        in_message_end;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        out_result_end;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  blk_req_t    req_q[$];
  blk_res_t    cipher_q[$];
  int          cycles;
  int          errors;
  int          sent_n;
  int          taken_n;

  // local model state
  logic [7:0]  sb_fwd[256];
  logic [7:0]  sb_inv[256];
  logic [63:0] key_reg[4];
  logic [1:0]  ksize;
  logic        cbc_on;
  logic [63:0] iv_hi, iv_lo;
  logic [63:0] chain_hi, chain_lo;
  logic [31:0] sched[60];
  logic [7:0]  st[16];

  aes_block_cipher_ecb_cbc_core dut (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int k = 0; k < 8; k++) begin
      if (b[0]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
      b = b >> 1;
    end
    return p;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    return (b << n) | (b >> (8 - n));
  endfunction

  // derive both S-boxes from the field inverse and the affine map
  function automatic void build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
      sb_fwd[x] = s;
      sb_inv[s] = x[7:0];
    end
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {sb_fwd[w[31:24]], sb_fwd[w[23:16]], sb_fwd[w[15:8]], sb_fwd[w[7:0]]};
  endfunction

  function automatic int key_words();
    return 4 + 2 * ((ksize > 2) ? 2 : ksize);
  endfunction

  function automatic void expand_schedule();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = key_words();
    total = 4 * (nk + 7);
    for (int i = 0; i < nk; i++)
      sched[i] = i[0] ? key_reg[i / 2][31:0] : key_reg[i / 2][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched[i - 1];
      if (i % nk == 0) begin
        rc = 8'h01;
        repeat ((i / nk - 1) % 10) rc = gmul(rc, 8'h02);
        t = sbox_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
      end else if (nk > 6 && i % nk == 4) begin
        t = sbox_word(t);
      end
      sched[i] = sched[i - nk] ^ t;
    end
  endfunction

  function automatic void add_rk(input int rnd);
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        st[4 * c + r] ^= sched[(rnd * 4 + c) % 60][31 - 8 * r -: 8];
  endfunction

  function automatic void shift_st(input bit inverse);
    logic [7:0] t[16];
    t = st;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inverse) st[r + 4 * ((c + r) & 3)] = t[r + 4 * c];
        else st[r + 4 * c] = t[r + 4 * ((c + r) & 3)];
  endfunction

  function automatic void sub_st(input bit inverse);
    for (int i = 0; i < 16; i++) st[i] = inverse ? sb_inv[st[i]] : sb_fwd[st[i]];
  endfunction

  function automatic void mix_st(input bit inverse);
    logic [7:0] m[4];
    logic [7:0] col[4];
    logic [7:0] v;
    if (inverse) m = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
    else m = '{8'h02, 8'h03, 8'h01, 8'h01};
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) col[k] = st[4 * c + k];
      for (int r = 0; r < 4; r++) begin
        v = 8'h00;
        for (int k = 0; k < 4; k++) v ^= gmul(col[k], m[(k + 4 - r) & 3]);
        st[4 * c + r] = v;
      end
    end
  endfunction

  // compute the block the core should return, and advance the chain
  function automatic blk_res_t aes_predict(input blk_req_t q);
    blk_res_t res;
    logic [63:0] hi, lo;
    int nr;
    nr = key_words() + 6;
    hi = q.hi;
    lo = q.lo;
    if (q.op == OP_ENC && cbc_on) begin
      hi ^= chain_hi;
      lo ^= chain_lo;
    end
    for (int i = 0; i < 8; i++) begin
      st[i] = hi[63 - 8 * i -: 8];
      st[8 + i] = lo[63 - 8 * i -: 8];
    end
    if (q.op == OP_ENC) begin
      add_rk(0);
      for (int r = 1; r < nr; r++) begin
        sub_st(0); shift_st(0); mix_st(0); add_rk(r);
      end
      sub_st(0); shift_st(0); add_rk(nr);
    end else begin
      add_rk(nr);
      for (int r = nr - 1; r > 0; r--) begin
        shift_st(1); sub_st(1); add_rk(r); mix_st(1);
      end
      shift_st(1); sub_st(1); add_rk(0);
    end
    for (int i = 0; i < 8; i++) begin
      res.hi[63 - 8 * i -: 8] = st[i];
      res.lo[63 - 8 * i -: 8] = st[8 + i];
    end
    if (cbc_on) begin
      if (q.op == OP_ENC) begin
        chain_hi = res.hi;
        chain_lo = res.lo;
      end else begin
        res.hi ^= chain_hi;
        res.lo ^= chain_lo;
        chain_hi = q.hi;
        chain_lo = q.lo;
      end
    end
    res.last = q.last;
    return res;
  endfunction

  function automatic void model_cfg(input logic [2:0] idx, input logic [63:0] val);
    case (idx)
      CFG_KEY0, CFG_KEY1, CFG_KEY2, CFG_KEY3: begin
        key_reg[idx[1:0]] = val;
        expand_schedule();
      end
      CFG_KSIZE: begin
        ksize = val[1:0];
        expand_schedule();
      end
      CFG_CHAIN: cbc_on = val[0];
      CFG_IVHI: begin
        iv_hi = val;
        chain_hi = iv_hi;
        chain_lo = iv_lo;
      end
      CFG_IVLO: begin
        iv_lo = val;
        chain_hi = iv_hi;
        chain_lo = iv_lo;
      end
      default: ;
    endcase
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // hold until every request has gone and every result has come back
  task automatic drain();
    while (req_q.size() != 0 || in_valid || cipher_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    model_cfg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    // key expansion runs in the background
    if (idx <= CFG_KSIZE) repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_key(input logic [63:0] k0, input logic [63:0] k1,
                         input logic [63:0] k2, input logic [63:0] k3,
                         input logic [1:0] ks);
    cfg_write(CFG_KSIZE, {62'h0, ks});
    cfg_write(CFG_KEY0, k0);
    cfg_write(CFG_KEY1, k1);
    cfg_write(CFG_KEY2, k2);
    cfg_write(CFG_KEY3, k3);
  endtask

  task automatic push(input logic op, input logic [63:0] hi, input logic [63:0] lo,
                      input logic last);
    blk_req_t q;
    q.op = op; q.hi = hi; q.lo = lo; q.last = last;
    req_q.push_back(q);
  endtask

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  function automatic bit quiet();
    return cycles >= 40000 && cycles < 80000;
  endfunction

  // stimulus
  initial begin
    logic [63:0] k[4];
    int n;
    build_sboxes();
    key_reg = '{default: 64'h0};
    ksize = 2'd0; cbc_on = 1'b0;
    iv_hi = 64'h0; iv_lo = 64'h0; chain_hi = 64'h0; chain_lo = 64'h0;
    for (int i = 0; i < 60; i++) sched[i] = 32'h0;
    errors = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = CFG_KEY0; cfg_wdata = 64'h0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: standard vectors, extremes and every key size
    set_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
            64'h18191a1b1c1d1e1f, 2'd0);
    push(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    push(OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1);
    push(OP_ENC, 64'h0, 64'h0, 1'b0);
    push(OP_ENC, '1, '1, 1'b1);
    push(OP_DEC, 64'h0, 64'h0, 1'b1);
    push(OP_DEC, '1, '1, 1'b0);
    drain();
    cfg_write(CFG_KSIZE, 64'd1);
    push(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    push(OP_DEC, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b1);
    drain();
    cfg_write(CFG_KSIZE, 64'd2);
    push(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    push(OP_DEC, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1);
    drain();
    // unused size code falls back to the 256-bit schedule
    cfg_write(CFG_KSIZE, 64'd3);
    push(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff, 1'b0);
    push(OP_DEC, '1, 64'h0, 1'b1);
    drain();
    set_key('1, '1, '1, '1, 2'd2);
    push(OP_ENC, '1, '1, 1'b0);
    push(OP_DEC, 64'h0, '1, 1'b1);
    drain();
    // CBC: encrypt a run, reload the IV, decrypt a run and encrypt one more block
    cfg_write(CFG_CHAIN, 64'd1);
    cfg_write(CFG_IVHI, 64'h0001020304050607);
    cfg_write(CFG_IVLO, 64'h08090a0b0c0d0e0f);
    push(OP_ENC, 64'h6bc1bee22e409f96, 64'he93d7e117393172a, 1'b0);
    push(OP_ENC, 64'hae2d8a571e03ac9c, 64'h9eb76fac45af8e51, 1'b1);
    drain();
    cfg_write(CFG_IVLO, 64'h08090a0b0c0d0e0f);
    push(OP_DEC, 64'hdeadbeefcafef00d, 64'h0123456789abcdef, 1'b0);
    push(OP_DEC, '1, '1, 1'b1);
    push(OP_ENC, 64'h0, 64'h0, 1'b0);
    drain();

    // random phases over key sizes, modes and IV reloads
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < 4; i++) k[i] = rand_half();
      set_key(k[0], k[1], k[2], k[3], ph[1:0]);
      cfg_write(CFG_CHAIN, {63'h0, ph[2] ^ ph[0]});
      cfg_write(CFG_IVHI, rand_half());
      cfg_write(CFG_IVLO, rand_half());
      n = $urandom_range(150, 200);
      for (int i = 0; i < n; i++) begin
        push(1'($urandom_range(0, 1)), rand_half(), rand_half(),
             1'($urandom_range(0, 1)));
        if (i == n / 2) begin
          drain();
          if ($urandom_range(0, 1)) cfg_write(CFG_IVHI, rand_half());
          else cfg_write(CFG_IVLO, rand_half());
          // a single key word change re-expands at the current size
          cfg_write(3'(CFG_KEY0 + $urandom_range(0, 3)), rand_half());
        end
      end
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_operation <= OP_ENC;
      in_block_high <= 64'h0;
      in_block_low <= 64'h0;
      in_message_end <= 1'b0;
    end else if (in_valid && taken_n != sent_n) begin
      // hold the request until it is taken
    end else if (req_q.size() != 0 && (quiet() || $urandom_range(0, 99) >= 31)) begin
      blk_req_t q;
      q = req_q.pop_front();
      sent_n++;
      in_valid <= 1'b1;
      in_operation <= q.op;
      in_block_high <= q.hi;
      in_block_low <= q.lo;
      in_message_end <= q.last;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= quiet() || $urandom_range(0, 99) >= 31;
  end

  // accept requests, predict, and check results
  always @(posedge clk) begin
    blk_req_t q;
    blk_res_t want;
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      q.op = in_operation; q.hi = in_block_high; q.lo = in_block_low;
      q.last = in_message_end;
      cipher_q.push_back(aes_predict(q));
      taken_n++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (cipher_q.size() == 0) begin
        report("unexpected result", out_result_high, out_result_low);
      end else begin
        want = cipher_q.pop_front();
        if (out_result_high !== want.hi) report("result_high", out_result_high, want.hi);
        if (out_result_low !== want.lo) report("result_low", out_result_low, want.lo);
        if (out_result_end !== want.last)
          report("result_end", {63'h0, out_result_end}, {63'h0, want.last});
      end
    end
  end

  initial cycles = 0;

endmodule
